>>> src/agpc_pkg.sv
package agpc_pkg;

   // item field widths
   localparam int FUNC_W    = 2;
   localparam int CODE_W    = 8;
   localparam int LEVEL_W   = 16;
   localparam int PLAYED_W  = 40;
   localparam int MS_W      = 32;
   localparam int QUEUED_W  = 32;
   localparam int UNDERRUN_W = 32;

   // configuration registers
   localparam int VOLUME_W  = 7;
   localparam int RATE_W    = 18;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = RATE_W;

   localparam logic [CSR_IDX_W-1:0] CSR_VOLUME = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE   = 1'b1;

   localparam logic [VOLUME_W-1:0] VOLUME_MAX   = 7'd100;
   localparam logic [VOLUME_W-1:0] VOLUME_RESET = 7'd25;

   // gain = volume * 256 / 100 = (volume * 5243) >> 11 for volume 0..100
   localparam int GAIN_W       = 9;
   localparam int GAIN_RECIP_W = 13;
   localparam logic [GAIN_RECIP_W-1:0] GAIN_RECIP = 13'd5243;
   localparam int GAIN_SHIFT   = 11;
   localparam int GAIN_PROD_W  = VOLUME_W + GAIN_RECIP_W;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 9'd64;

   localparam logic [LEVEL_W-1:0] MIDSCALE = 16'h8000;
   localparam logic [CODE_W:0]    CODE_MID = 9'd128;

   // item kinds
   localparam logic [FUNC_W-1:0] FUNC_SAMPLE        = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DONE          = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DONE_UNDERRUN = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_RESTART       = 2'd3;

   // ring geometry
   localparam int BUF_FRAMES = 256;
   localparam int BUF_COUNT  = 8;
   localparam logic [PLAYED_W-1:0] BUF_STEP = PLAYED_W'(BUF_FRAMES);
   localparam logic [PLAYED_W-1:0] RING_CAP = PLAYED_W'(BUF_COUNT * BUF_FRAMES);

   // playback clock divider: played*1000 fits in 50 bits, two quotient bits a cycle
   localparam int NUM_W          = PLAYED_W + 10;
   localparam int DIV_CYCLES     = NUM_W / 2;
   localparam int DIV_CNT_W      = $clog2(DIV_CYCLES);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_CYCLES - 1);

   // controller to datapath
   typedef struct packed {
      logic take_item;
      logic calc_played;
      logic calc_num;
      logic div_step;
      logic load_out;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_full;
   } stat_type;

endpackage

>>> src/agpc_req_if.sv
interface agpc_req_if;
   import agpc_pkg::*;

   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [CODE_W-1:0] sample_code;

   modport source (output valid, output func, output sample_code, input ready);
   modport sink   (input valid, input func, input sample_code, output ready);
endinterface

>>> src/agpc_rsp_if.sv
interface agpc_rsp_if;
   import agpc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [LEVEL_W-1:0]    level_word;
   logic [PLAYED_W-1:0]   samples_played;
   logic [MS_W-1:0]       clock_ms;
   logic [QUEUED_W-1:0]   queued_samples;
   logic [UNDERRUN_W-1:0] underrun_total;

   modport source (output valid, output level_word, output samples_played,
                   output clock_ms, output queued_samples, output underrun_total,
                   input ready);
   modport sink   (input valid, input level_word, input samples_played,
                   input clock_ms, input queued_samples, input underrun_total,
                   output ready);
endinterface

>>> src/agpc_ctrl.sv
module agpc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  agpc_pkg::stat_type stat,
   output agpc_pkg::cmd_type  cmd
);
   import agpc_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_PLAYED = 3'd1;
   localparam logic [2:0] S_MUL    = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_FIN    = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   assign req_ready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take_item = 1'b1;
               state_in      = S_PLAYED;
            end
         end
         S_PLAYED: begin
            cmd.calc_played = 1'b1;
            state_in        = S_MUL;
         end
         S_MUL: begin
            cmd.calc_num = 1'b1;
            cnt_in       = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!stat.out_full) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

>>> src/agpc_dp.sv
module agpc_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [agpc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [agpc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic [agpc_pkg::FUNC_W-1:0]          func,
   input  logic [agpc_pkg::CODE_W-1:0]          sample_code,
   input  agpc_pkg::cmd_type                    cmd,
   output agpc_pkg::stat_type                   stat,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic [agpc_pkg::LEVEL_W-1:0]         level_word,
   output logic [agpc_pkg::PLAYED_W-1:0]        samples_played,
   output logic [agpc_pkg::MS_W-1:0]            clock_ms,
   output logic [agpc_pkg::QUEUED_W-1:0]        queued_samples,
   output logic [agpc_pkg::UNDERRUN_W-1:0]      underrun_total
);
   import agpc_pkg::*;

   logic [GAIN_W-1:0]      gain_ff;
   logic [RATE_W-1:0]      rate_ff;
   logic [VOLUME_W-1:0]    vol_clamp;
   logic [GAIN_PROD_W-1:0] gain_prod;

   logic [PLAYED_W-1:0]    written_ff, written_in;
   logic [PLAYED_W-1:0]    tally_ff, tally_in;
   logic [UNDERRUN_W-1:0]  underrun_ff, underrun_in;

   logic signed [CODE_W:0]         ofs;
   logic signed [GAIN_W:0]         gain_s;
   logic signed [CODE_W+GAIN_W+1:0] prod;
   logic [LEVEL_W-1:0]     level_ff, level_in;

   logic [PLAYED_W-1:0]    played_ff;
   logic [QUEUED_W-1:0]    queued_ff;
   logic [NUM_W-1:0]       num;
   logic [NUM_W-1:0]       dq_ff, dq_in;
   logic [RATE_W-1:0]      rem_ff, rem_in;
   logic [RATE_W:0]        t0, t1;
   logic [RATE_W-1:0]      r0;
   logic                   q0, q1;

   logic                   out_valid_ff;
   logic [LEVEL_W-1:0]     out_level_ff;
   logic [PLAYED_W-1:0]    out_played_ff;
   logic [MS_W-1:0]        out_ms_ff;
   logic [QUEUED_W-1:0]    out_queued_ff;
   logic [UNDERRUN_W-1:0]  out_underrun_ff;

   // volume clamp and gain via reciprocal multiply
   assign vol_clamp = (csr_wdata[VOLUME_W-1:0] > VOLUME_MAX) ? VOLUME_MAX
                                                            : csr_wdata[VOLUME_W-1:0];
   assign gain_prod = GAIN_PROD_W'(vol_clamp) * GAIN_PROD_W'(GAIN_RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
         rate_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_VOLUME: gain_ff <= gain_prod[GAIN_SHIFT +: GAIN_W];
            CSR_RATE:   rate_ff <= csr_wdata[RATE_W-1:0];
            default:    rate_ff <= rate_ff;
         endcase
      end
   end

   // sample scaling about midscale
   assign ofs    = $signed({1'b0, sample_code}) - $signed(CODE_MID);
   assign gain_s = $signed({1'b0, gain_ff});
   assign prod   = ofs * gain_s;

   // counter update for the taken item
   always_comb begin
      written_in  = written_ff;
      tally_in    = tally_ff;
      underrun_in = underrun_ff;
      level_in    = MIDSCALE;
      unique case (func)
         FUNC_SAMPLE: begin
            level_in   = prod[LEVEL_W-1:0] + MIDSCALE;
            written_in = written_ff + 1'b1;
         end
         FUNC_DONE: begin
            tally_in = tally_ff + BUF_STEP;
         end
         FUNC_DONE_UNDERRUN: begin
            tally_in    = tally_ff + BUF_STEP;
            underrun_in = underrun_ff + 1'b1;
         end
         FUNC_RESTART: begin
            written_in  = '0;
            tally_in    = '0;
            underrun_in = '0;
         end
         default: begin
            level_in = MIDSCALE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff  <= '0;
         tally_ff    <= '0;
         underrun_ff <= '0;
      end else if (cmd.take_item) begin
         written_ff  <= written_in;
         tally_ff    <= tally_in;
         underrun_ff <= underrun_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         level_ff <= level_in;
      end
   end

   // played = tally minus ring capacity, floored at zero; then queued and x1000
   assign num = {played_ff, 10'b0} - {6'b0, played_ff, 4'b0} - {7'b0, played_ff, 3'b0};

   always_ff @(posedge clock) begin
      if (cmd.calc_played) begin
         played_ff <= (tally_ff > RING_CAP) ? tally_ff - RING_CAP : '0;
      end
      if (cmd.calc_num) begin
         queued_ff <= (written_ff > played_ff) ? QUEUED_W'(written_ff - played_ff) : '0;
      end
   end

   // restoring divider, two quotient bits per cycle
   assign t0 = {rem_ff, dq_ff[NUM_W-1]};
   assign q0 = (t0 >= {1'b0, rate_ff});
   assign r0 = q0 ? RATE_W'(t0 - {1'b0, rate_ff}) : t0[RATE_W-1:0];
   assign t1 = {r0, dq_ff[NUM_W-2]};
   assign q1 = (t1 >= {1'b0, rate_ff});

   always_comb begin
      dq_in  = {dq_ff[NUM_W-3:0], q0, q1};
      rem_in = q1 ? RATE_W'(t1 - {1'b0, rate_ff}) : t1[RATE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.calc_num) begin
         dq_ff  <= num;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         dq_ff  <= dq_in;
         rem_ff <= rem_in;
      end
   end

   // output word register
   assign stat.out_full = out_valid_ff && !rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_level_ff    <= level_ff;
         out_played_ff   <= played_ff;
         out_ms_ff       <= (rate_ff == '0) ? '0 : dq_ff[MS_W-1:0];
         out_queued_ff   <= queued_ff;
         out_underrun_ff <= underrun_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign level_word     = out_level_ff;
   assign samples_played = out_played_ff;
   assign clock_ms       = out_ms_ff;
   assign queued_samples = out_queued_ff;
   assign underrun_total = out_underrun_ff;

endmodule

>>> src/audio_gain_and_playback_clock_core.sv
// Audio gain stage and playback clock.
// req_ch carries one word per item: func selects a sample (scaled about
// midscale by volume*256/100), a buffer-done event, a buffer-done event with
// underrun, or a restart that clears all counters. rsp_ch returns one word per
// item with the DAC level and the playback counters after the item.
// csr_wr_en/csr_index/csr_wdata write volume (index 0, clamped to 100) and the
// sample rate (index 1); write only while no item is in flight.
// After acceptance an item steps through the played, multiply, division and
// finish states before its result word is loaded into the output register;
// the 50-bit millisecond division runs two quotient bits a cycle.
// The block takes one item at a time; req_ch.ready is high while idle, and the
// next item may be taken while the previous result still waits in the output
// register.
// If rsp_ch stalls, a finished item holds in the datapath until the output
// register frees, and no new item is taken meanwhile.
// Reset (synchronous, active high) clears the counters, sets volume to 25 and
// the rate to 0, and empties the output register.
module audio_gain_and_playback_clock_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [agpc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [agpc_pkg::CSR_DATA_W-1:0] csr_wdata,
   agpc_req_if.sink                        req_ch,
   agpc_rsp_if.source                      rsp_ch
);
   import agpc_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   agpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // counters, scaling, divider and output register
   agpc_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .func           (req_ch.func),
      .sample_code    (req_ch.sample_code),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_ready      (rsp_ch.ready),
      .rsp_valid      (rsp_ch.valid),
      .level_word     (rsp_ch.level_word),
      .samples_played (rsp_ch.samples_played),
      .clock_ms       (rsp_ch.clock_ms),
      .queued_samples (rsp_ch.queued_samples),
      .underrun_total (rsp_ch.underrun_total)
   );

   // no new word is taken while the divider runs
   a_busy_no_take: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> !req_ch.ready)
      else $error("request taken during division");

   // an accepted word moves straight to the played calculation
   a_take_then_played: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> cmd.calc_played)
      else $error("accepted word not processed");

   // the output register is never overwritten while it holds an untaken word
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !(rsp_ch.valid && !rsp_ch.ready))
      else $error("result overwritten");

   // a loaded result is presented on the next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_ch.valid)
      else $error("loaded result not presented");

endmodule
